[hw/rtl/pctb_pkg.sv]
// Shared constants, codes and controller/datapath interface types of the prefix code tree builder.
package pctb_pkg;

    // Default sizes
    localparam int ALPHABET_SIZE_DEF = 128;
    localparam int MAX_CODE_BITS_DEF = 32;
    localparam int COUNT_BITS_DEF    = 16;

    // Field widths
    localparam int MODE_W   = 2;
    localparam int SYM_W    = 7;
    localparam int PATH_W   = 32;
    localparam int PLEN_W   = 6;
    localparam int CLEN_W   = 6;
    localparam int DIST_W   = 7;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 56;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ENC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DEC = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_CNT_RD, S_CNT_WR, S_B_INIT, S_SCAN_RD, S_SCAN_CHK,
        S_INS_RD, S_INS_CMP, S_INS_WR, S_M_CHK, S_M_RDA, S_M_RDB, S_M_SUM,
        S_M_SRD, S_M_SCMP, S_M_SWR, S_ROOT_RD, S_ROOT_SET, S_C_RD, S_C_L,
        S_C_R, S_ENC_RD, S_DEC_START, S_D_STEP, S_D_NEXT, S_EMIT
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_ACCEPT, OP_CNT_RD, OP_CNT_WR, OP_B_INIT, OP_SCAN_RD,
        OP_SCAN_CHK, OP_INS_RD, OP_INS_CMP, OP_INS_WR, OP_M_RDA, OP_M_RDB,
        OP_M_SUM, OP_M_SRD, OP_M_SCMP, OP_M_SWR, OP_ROOT_RD, OP_ROOT_SET,
        OP_C_RD, OP_C_L, OP_C_R, OP_ENC_RD, OP_DEC_START, OP_D_STEP,
        OP_D_NEXT, OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic msg_end;
        logic out_free;
        logic scan_hit;
        logic scan_last;
        logic n_zero;
        logic pos_one;
        logic ins_gt;
        logic merge_more;
        logic m_tail;
        logic sc_lt;
        logic p_next_in;
        logic root_leaf;
        logic i_zero;
        logic d_done;
        logic cur_leaf;
        logic root_valid;
    } dp_status_t;

endpackage

[hw/rtl/pctb_ctrl.sv]
// Controller state machine: sequences counting, tree build, code pass and queries.
module pctb_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [pctb_pkg::MODE_W-1:0]  in_mode,
    output logic                         in_ready,
    output pctb_pkg::dp_cmd_t            cmd,
    input  pctb_pkg::dp_status_t         st
);
    import pctb_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_mode)
                        MODE_ADD: state_next = S_CNT_RD;
                        MODE_ENC: state_next = S_ENC_RD;
                        MODE_DEC: state_next = S_DEC_START;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_CNT_RD:   state_next = S_CNT_WR;
            S_CNT_WR:   state_next = st.msg_end ? S_B_INIT : S_IDLE;
            S_B_INIT:   state_next = S_SCAN_RD;
            S_SCAN_RD:  state_next = S_SCAN_CHK;
            S_SCAN_CHK:
            begin
                if (st.scan_hit)
                begin
                    state_next = st.n_zero ? S_INS_WR : S_INS_RD;
                end
                else
                begin
                    state_next = st.scan_last ? S_M_CHK : S_SCAN_RD;
                end
            end
            S_INS_RD:   state_next = S_INS_CMP;
            S_INS_CMP:
            begin
                if (st.ins_gt && !st.pos_one)
                begin
                    state_next = S_INS_RD;
                end
                else
                begin
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:   state_next = st.scan_last ? S_M_CHK : S_SCAN_RD;
            S_M_CHK:
            begin
                if (st.n_zero)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = st.merge_more ? S_M_RDA : S_ROOT_RD;
                end
            end
            S_M_RDA:    state_next = S_M_RDB;
            S_M_RDB:    state_next = S_M_SUM;
            S_M_SUM:    state_next = st.m_tail ? S_M_SRD : S_M_SWR;
            S_M_SRD:    state_next = S_M_SCMP;
            S_M_SCMP:   state_next = (st.sc_lt && st.p_next_in) ? S_M_SRD : S_M_SWR;
            S_M_SWR:    state_next = S_M_CHK;
            S_ROOT_RD:  state_next = S_ROOT_SET;
            S_ROOT_SET: state_next = st.root_leaf ? S_EMIT : S_C_RD;
            S_C_RD:     state_next = S_C_L;
            S_C_L:      state_next = S_C_R;
            S_C_R:      state_next = st.i_zero ? S_EMIT : S_C_RD;
            S_ENC_RD:   state_next = S_EMIT;
            S_DEC_START: state_next = st.root_valid ? S_D_STEP : S_EMIT;
            S_D_STEP:   state_next = (st.d_done || st.cur_leaf) ? S_EMIT : S_D_NEXT;
            S_D_NEXT:   state_next = S_D_STEP;
            S_EMIT:     state_next = st.out_free ? S_IDLE : S_EMIT;
            default:    state_next = S_IDLE;
        endcase
    end

    // Drive datapath commands
    always_comb
    begin
        in_ready = 1'b0;
        cmd.op   = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.op   = in_valid ? OP_ACCEPT : OP_NONE;
            end
            S_CNT_RD:    cmd.op = OP_CNT_RD;
            S_CNT_WR:    cmd.op = OP_CNT_WR;
            S_B_INIT:    cmd.op = OP_B_INIT;
            S_SCAN_RD:   cmd.op = OP_SCAN_RD;
            S_SCAN_CHK:  cmd.op = OP_SCAN_CHK;
            S_INS_RD:    cmd.op = OP_INS_RD;
            S_INS_CMP:   cmd.op = OP_INS_CMP;
            S_INS_WR:    cmd.op = OP_INS_WR;
            S_M_CHK:     cmd.op = OP_NONE;
            S_M_RDA:     cmd.op = OP_M_RDA;
            S_M_RDB:     cmd.op = OP_M_RDB;
            S_M_SUM:     cmd.op = OP_M_SUM;
            S_M_SRD:     cmd.op = OP_M_SRD;
            S_M_SCMP:    cmd.op = OP_M_SCMP;
            S_M_SWR:     cmd.op = OP_M_SWR;
            S_ROOT_RD:   cmd.op = OP_ROOT_RD;
            S_ROOT_SET:  cmd.op = OP_ROOT_SET;
            S_C_RD:      cmd.op = OP_C_RD;
            S_C_L:       cmd.op = OP_C_L;
            S_C_R:       cmd.op = OP_C_R;
            S_ENC_RD:    cmd.op = OP_ENC_RD;
            S_DEC_START: cmd.op = OP_DEC_START;
            S_D_STEP:    cmd.op = OP_D_STEP;
            S_D_NEXT:    cmd.op = OP_D_NEXT;
            S_EMIT:      cmd.op = st.out_free ? OP_EMIT : OP_NONE;
            default:     cmd.op = OP_NONE;
        endcase
    end

endmodule

[hw/rtl/pctb_datapath.sv]
// Datapath: count, order list, node and code memories, counters and output register.
module pctb_datapath #(
    parameter int ALPHABET_SIZE = pctb_pkg::ALPHABET_SIZE_DEF,
    parameter int MAX_CODE_BITS = pctb_pkg::MAX_CODE_BITS_DEF,
    parameter int COUNT_BITS    = pctb_pkg::COUNT_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pctb_pkg::dp_cmd_t            cmd,
    output pctb_pkg::dp_status_t         st,
    input  logic [pctb_pkg::MODE_W-1:0]  in_mode,
    input  logic [pctb_pkg::SYM_W-1:0]   in_symbol,
    input  logic                         in_message_end,
    input  logic [pctb_pkg::PATH_W-1:0]  in_path_bits,
    input  logic [pctb_pkg::PLEN_W-1:0]  in_path_length,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [pctb_pkg::PATH_W-1:0]  code_bits,
    output logic [pctb_pkg::CLEN_W-1:0]  code_length,
    output logic                         found,
    output logic [pctb_pkg::SYM_W-1:0]   decoded_symbol,
    output logic [pctb_pkg::DIST_W-1:0]  distinct_symbols,
    output logic                         overflow
);
    import pctb_pkg::*;

    localparam int AW    = $clog2(ALPHABET_SIZE);
    localparam int WW    = COUNT_BITS + AW;
    localparam int EW    = WW + 1 + AW;
    localparam int NW    = 2 * (1 + AW);
    localparam int CW    = MAX_CODE_BITS + AW;
    localparam int NODES = ALPHABET_SIZE - 1;

    // Memories
    logic [COUNT_BITS-1:0] cnt_mem  [ALPHABET_SIZE];
    logic [EW-1:0]         list_mem [ALPHABET_SIZE];
    logic [NW-1:0]         node_mem [NODES];
    logic [CW-1:0]         nc_mem   [NODES];
    logic [CW-1:0]         ct_mem   [ALPHABET_SIZE];

    logic [COUNT_BITS-1:0] cnt_rd;
    logic [EW-1:0]         list_rd;
    logic [NW-1:0]         node_rd;
    logic [CW-1:0]         nc_rd;
    logic [CW-1:0]         ct_rd;

    // Memory port controls
    logic                  cnt_re, cnt_we;
    logic [AW-1:0]         cnt_raddr, cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic                  list_re, list_we;
    logic [AW-1:0]         list_raddr, list_waddr;
    logic [EW-1:0]         list_wdata;
    logic                  node_re, node_we;
    logic [AW-1:0]         node_raddr, node_waddr;
    logic [NW-1:0]         node_wdata;
    logic                  nc_re, nc_we;
    logic [AW-1:0]         nc_raddr, nc_waddr;
    logic [CW-1:0]         nc_wdata;
    logic                  ct_re, ct_we;
    logic [AW-1:0]         ct_raddr, ct_waddr;
    logic [CW-1:0]         ct_wdata;

    // Latched item
    logic [MODE_W-1:0]     mode_reg;
    logic [SYM_W-1:0]      sym_reg;
    logic                  end_reg;
    logic [PATH_W-1:0]     path_reg;
    logic [PLEN_W-1:0]     plen_reg;

    // Control state
    logic                     started_reg, sat_reg, too_long_reg, root_valid_reg, fail_reg;
    logic [ALPHABET_SIZE-1:0] cnt_vld_reg, present_reg;
    logic [AW-1:0]            s_reg, n_reg, pos_reg, h_reg, p_reg, k_reg, i_reg;
    logic [PLEN_W-1:0]        di_reg;

    // Build and query payload
    logic [WW-1:0]         w_reg, sum_reg;
    logic [EW-1:0]         a_reg;
    logic [AW:0]           root_reg, cur_reg;

    // Output register
    logic [PATH_W-1:0]     code_bits_reg;
    logic [CLEN_W-1:0]     code_length_reg;
    logic                  found_reg, overflow_reg, out_valid_reg;
    logic [SYM_W-1:0]      decoded_reg;
    logic [DIST_W-1:0]     distinct_reg;

    // Decoded fields
    logic                  sym_ok;
    logic [AW-1:0]         sym_idx;
    logic [COUNT_BITS-1:0] cnt_cur, scan_w;
    logic                  cnt_full;
    logic [WW-1:0]         lr_w, a_w, sum_next;
    logic                  lr_leaf, a_leaf;
    logic [AW-1:0]         lr_id, a_id;
    logic                  nd_lleaf, nd_rleaf;
    logic [AW-1:0]         nd_lid, nd_rid;
    logic [MAX_CODE_BITS-1:0] nc_code, code_r, ct_code;
    logic [AW-1:0]         nc_d, cd, ct_d;
    logic                  cd_long;
    logic [AW:0]           h_ext, n_ext, p_ext;
    logic                  enc_found;
    logic [8:0]            len9, lsat9, n9;
    logic [MAX_CODE_BITS+PATH_W-1:0] code_wide;
    logic                  out_free;

    assign sym_ok   = (sym_reg != '0) && (int'(sym_reg) < ALPHABET_SIZE);
    assign sym_idx  = AW'(sym_reg);
    assign cnt_cur  = cnt_vld_reg[sym_idx] ? cnt_rd : '0;
    assign cnt_full = &cnt_cur;
    assign scan_w   = cnt_vld_reg[s_reg] ? cnt_rd : '0;

    assign lr_w     = list_rd[EW-1 -: WW];
    assign lr_leaf  = list_rd[AW];
    assign lr_id    = list_rd[AW-1:0];
    assign a_w      = a_reg[EW-1 -: WW];
    assign a_leaf   = a_reg[AW];
    assign a_id     = a_reg[AW-1:0];
    assign sum_next = a_w + lr_w;

    assign nd_lleaf = node_rd[NW-1];
    assign nd_lid   = node_rd[NW-2 -: AW];
    assign nd_rleaf = node_rd[AW];
    assign nd_rid   = node_rd[AW-1:0];

    // Child codes: right child sets the bit of the parent's depth while it fits
    assign nc_code  = nc_rd[CW-1 -: MAX_CODE_BITS];
    assign nc_d     = nc_rd[AW-1:0];
    assign cd       = nc_d + AW'(1);
    assign cd_long  = int'(cd) > MAX_CODE_BITS;
    assign code_r   = (int'(nc_d) < MAX_CODE_BITS)
                      ? (nc_code | (MAX_CODE_BITS'(1) << nc_d)) : nc_code;

    assign ct_code  = ct_rd[CW-1 -: MAX_CODE_BITS];
    assign ct_d     = ct_rd[AW-1:0];

    assign h_ext    = {1'b0, h_reg};
    assign n_ext    = {1'b0, n_reg};
    assign p_ext    = {1'b0, p_reg};
    assign out_free = !out_valid_reg || out_ready;

    // Status to controller
    assign st.msg_end    = end_reg;
    assign st.out_free   = out_free;
    assign st.scan_hit   = scan_w != '0;
    assign st.scan_last  = s_reg == AW'(ALPHABET_SIZE - 1);
    assign st.n_zero     = n_reg == '0;
    assign st.pos_one    = pos_reg == AW'(1);
    assign st.ins_gt     = lr_w > w_reg;
    assign st.merge_more = (h_ext + (AW+1)'(2)) <= n_ext;
    assign st.m_tail     = (h_ext + (AW+1)'(2)) < n_ext;
    assign st.sc_lt      = lr_w < sum_reg;
    assign st.p_next_in  = (p_ext + (AW+1)'(1)) < n_ext;
    assign st.root_leaf  = lr_leaf;
    assign st.i_zero     = i_reg == '0;
    assign st.d_done     = di_reg == plen_reg;
    assign st.cur_leaf   = cur_reg[AW];
    assign st.root_valid = root_valid_reg;

    // Steer memory ports
    always_comb
    begin
        cnt_re = 1'b0; cnt_we = 1'b0; cnt_raddr = sym_idx; cnt_waddr = sym_idx;
        cnt_wdata = cnt_cur + COUNT_BITS'(1);
        list_re = 1'b0; list_we = 1'b0; list_raddr = h_reg; list_waddr = pos_reg;
        list_wdata = list_rd;
        node_re = 1'b0; node_we = 1'b0; node_raddr = i_reg; node_waddr = k_reg;
        node_wdata = {a_leaf, a_id, lr_leaf, lr_id};
        nc_re = 1'b0; nc_we = 1'b0; nc_raddr = i_reg; nc_waddr = nd_lid;
        nc_wdata = {nc_code, cd};
        ct_re = 1'b0; ct_we = 1'b0; ct_raddr = sym_idx; ct_waddr = nd_lid;
        ct_wdata = {nc_code, cd};
        case (cmd.op)
            OP_CNT_RD:
            begin
                cnt_re = 1'b1;
            end
            OP_CNT_WR:
            begin
                cnt_we = sym_ok && !cnt_full;
            end
            OP_SCAN_RD:
            begin
                cnt_re    = 1'b1;
                cnt_raddr = s_reg;
            end
            OP_INS_RD:
            begin
                list_re    = 1'b1;
                list_raddr = pos_reg - AW'(1);
            end
            OP_INS_CMP:
            begin
                list_we = st.ins_gt;
            end
            OP_INS_WR:
            begin
                list_we    = 1'b1;
                list_wdata = {w_reg, 1'b1, s_reg};
            end
            OP_M_RDA:
            begin
                list_re = 1'b1;
            end
            OP_M_RDB:
            begin
                list_re    = 1'b1;
                list_raddr = h_reg + AW'(1);
            end
            OP_M_SUM:
            begin
                node_we = 1'b1;
            end
            OP_M_SRD:
            begin
                list_re    = 1'b1;
                list_raddr = p_reg;
            end
            OP_M_SCMP:
            begin
                list_we    = st.sc_lt;
                list_waddr = p_reg - AW'(1);
            end
            OP_M_SWR:
            begin
                list_we    = 1'b1;
                list_waddr = p_reg - AW'(1);
                list_wdata = {sum_reg, 1'b0, k_reg};
            end
            OP_ROOT_RD:
            begin
                list_re = 1'b1;
            end
            OP_ROOT_SET:
            begin
                ct_we    = lr_leaf;
                ct_waddr = lr_id;
                ct_wdata = '0;
                nc_we    = !lr_leaf;
                nc_waddr = k_reg - AW'(1);
                nc_wdata = '0;
            end
            OP_C_RD:
            begin
                node_re = 1'b1;
                nc_re   = 1'b1;
            end
            OP_C_L:
            begin
                ct_we = nd_lleaf;
                nc_we = !nd_lleaf;
            end
            OP_C_R:
            begin
                ct_we    = nd_rleaf;
                ct_waddr = nd_rid;
                ct_wdata = {code_r, cd};
                nc_we    = !nd_rleaf;
                nc_waddr = nd_rid;
                nc_wdata = {code_r, cd};
            end
            OP_ENC_RD:
            begin
                ct_re = 1'b1;
            end
            OP_D_STEP:
            begin
                node_re    = !st.d_done && !st.cur_leaf;
                node_raddr = cur_reg[AW-1:0];
            end
            default:
            begin
                cnt_re = 1'b0;
            end
        endcase
    end

    // Memory arrays with registered reads
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re)
        begin
            cnt_rd <= cnt_mem[cnt_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (list_we)
        begin
            list_mem[list_waddr] <= list_wdata;
        end
        if (list_re)
        begin
            list_rd <= list_mem[list_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
        if (node_re)
        begin
            node_rd <= node_mem[node_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (nc_we)
        begin
            nc_mem[nc_waddr] <= nc_wdata;
        end
        if (nc_re)
        begin
            nc_rd <= nc_mem[nc_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ct_we)
        begin
            ct_mem[ct_waddr] <= ct_wdata;
        end
        if (ct_re)
        begin
            ct_rd <= ct_mem[ct_raddr];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg    <= 1'b0;
            sat_reg        <= 1'b0;
            too_long_reg   <= 1'b0;
            root_valid_reg <= 1'b0;
            fail_reg       <= 1'b0;
            cnt_vld_reg    <= '0;
            present_reg    <= '0;
            s_reg          <= '0;
            n_reg          <= '0;
            pos_reg        <= '0;
            h_reg          <= '0;
            p_reg          <= '0;
            k_reg          <= '0;
            i_reg          <= '0;
            di_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_ACCEPT:
                begin
                    // First character of a message clears all counts
                    if (in_mode == MODE_ADD && !started_reg)
                    begin
                        started_reg <= 1'b1;
                        sat_reg     <= 1'b0;
                        cnt_vld_reg <= '0;
                    end
                end
                OP_CNT_WR:
                begin
                    if (sym_ok)
                    begin
                        if (cnt_full)
                        begin
                            sat_reg <= 1'b1;
                        end
                        else
                        begin
                            cnt_vld_reg[sym_idx] <= 1'b1;
                        end
                    end
                end
                OP_B_INIT:
                begin
                    started_reg    <= 1'b0;
                    present_reg    <= '0;
                    root_valid_reg <= 1'b0;
                    too_long_reg   <= 1'b0;
                    s_reg          <= AW'(1);
                    n_reg          <= '0;
                    h_reg          <= '0;
                    k_reg          <= '0;
                end
                OP_SCAN_CHK:
                begin
                    if (st.scan_hit)
                    begin
                        pos_reg <= n_reg;
                    end
                    else
                    begin
                        s_reg <= s_reg + AW'(1);
                    end
                end
                OP_INS_CMP:
                begin
                    if (st.ins_gt)
                    begin
                        pos_reg <= pos_reg - AW'(1);
                    end
                end
                OP_INS_WR:
                begin
                    n_reg <= n_reg + AW'(1);
                    s_reg <= s_reg + AW'(1);
                end
                OP_M_SUM:
                begin
                    p_reg <= h_reg + AW'(2);
                end
                OP_M_SCMP:
                begin
                    if (st.sc_lt)
                    begin
                        p_reg <= p_reg + AW'(1);
                    end
                end
                OP_M_SWR:
                begin
                    h_reg <= h_reg + AW'(1);
                    k_reg <= k_reg + AW'(1);
                end
                OP_ROOT_SET:
                begin
                    root_valid_reg <= 1'b1;
                    if (lr_leaf)
                    begin
                        present_reg[lr_id] <= 1'b1;
                    end
                    else
                    begin
                        i_reg <= k_reg - AW'(1);
                    end
                end
                OP_C_L:
                begin
                    if (nd_lleaf)
                    begin
                        present_reg[nd_lid] <= 1'b1;
                        if (cd_long)
                        begin
                            too_long_reg <= 1'b1;
                        end
                    end
                end
                OP_C_R:
                begin
                    if (nd_rleaf)
                    begin
                        present_reg[nd_rid] <= 1'b1;
                        if (cd_long)
                        begin
                            too_long_reg <= 1'b1;
                        end
                    end
                    i_reg <= i_reg - AW'(1);
                end
                OP_DEC_START:
                begin
                    fail_reg <= 1'b0;
                    di_reg   <= '0;
                end
                OP_D_STEP:
                begin
                    if (!st.d_done && st.cur_leaf)
                    begin
                        fail_reg <= 1'b1;
                    end
                end
                OP_D_NEXT:
                begin
                    di_reg <= di_reg + PLEN_W'(1);
                end
                OP_EMIT:
                begin
                    out_valid_reg <= 1'b1;
                end
                default:
                begin
                    started_reg <= started_reg;
                end
            endcase
        end
    end

    // Result fields
    assign enc_found = root_valid_reg && sym_ok && present_reg[sym_idx];
    assign len9      = 9'(ct_d);
    assign lsat9     = (len9 > 9'(MAX_CODE_BITS)) ? 9'(MAX_CODE_BITS) : len9;
    assign n9        = 9'(n_reg);
    assign code_wide = (MAX_CODE_BITS+PATH_W)'(ct_code);

    // Payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_ACCEPT:
            begin
                mode_reg <= in_mode;
                sym_reg  <= in_symbol;
                end_reg  <= in_message_end;
                path_reg <= in_path_bits;
                plen_reg <= (in_path_length > PLEN_W'(PATH_W)) ? PLEN_W'(PATH_W)
                                                              : in_path_length;
            end
            OP_SCAN_CHK:
            begin
                w_reg <= WW'(scan_w);
            end
            OP_M_RDB:
            begin
                a_reg <= list_rd;
            end
            OP_M_SUM:
            begin
                sum_reg <= sum_next;
            end
            OP_ROOT_SET:
            begin
                root_reg <= {lr_leaf, lr_id};
            end
            OP_DEC_START:
            begin
                cur_reg <= root_reg;
            end
            OP_D_NEXT:
            begin
                cur_reg <= path_reg[di_reg[4:0]] ? {nd_rleaf, nd_rid} : {nd_lleaf, nd_lid};
            end
            OP_EMIT:
            begin
                code_bits_reg    <= '0;
                code_length_reg  <= '0;
                found_reg        <= 1'b0;
                decoded_reg      <= '0;
                distinct_reg     <= '0;
                overflow_reg     <= 1'b0;
                case (mode_reg)
                    MODE_ADD:
                    begin
                        distinct_reg <= (n9 > 9'd127) ? 7'd127 : n9[6:0];
                        overflow_reg <= sat_reg || too_long_reg;
                    end
                    MODE_ENC:
                    begin
                        if (enc_found)
                        begin
                            code_bits_reg   <= code_wide[PATH_W-1:0];
                            code_length_reg <= lsat9[CLEN_W-1:0];
                            found_reg       <= 1'b1;
                            overflow_reg    <= len9 > 9'(MAX_CODE_BITS);
                        end
                    end
                    MODE_DEC:
                    begin
                        if (root_valid_reg && !fail_reg && cur_reg[AW])
                        begin
                            decoded_reg <= SYM_W'(cur_reg[AW-1:0]);
                        end
                    end
                    default:
                    begin
                        found_reg <= 1'b0;
                    end
                endcase
            end
            default:
            begin
                mode_reg <= mode_reg;
            end
        endcase
    end

    assign out_valid        = out_valid_reg;
    assign code_bits        = code_bits_reg;
    assign code_length      = code_length_reg;
    assign found            = found_reg;
    assign decoded_symbol   = decoded_reg;
    assign distinct_symbols = distinct_reg;
    assign overflow         = overflow_reg;

    // The list head never passes the number of leaves
    assert property (@(posedge clk) disable iff (!rst_n) h_reg <= n_reg)
        else $error("order list head beyond leaf count");

    // Insertion reads only below a nonzero position
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_INS_RD |-> pos_reg != '0)
        else $error("insertion read at position zero");

    // Merge scan stays inside the live list
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_M_SCMP |-> p_reg < n_reg)
        else $error("merge scan beyond list end");

    // A loaded result is presented on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_EMIT |=> out_valid_reg)
        else $error("result load lost");

endmodule

[hw/rtl/prefix_code_tree_builder.sv]
// Top level of the prefix code tree builder: stream ports, controller and datapath.
//
// Input stream (s_axis): one transaction per item. tuser carries the mode (add
// character, encode query, decode query), tlast marks the last character of a
// message, tdata carries symbol, path bits and path length.
// Output stream (m_axis): one transaction per build, encode or decode; an add
// character item without tlast produces nothing.
// An add character item passes through accept, count read and count write, the
// read-modify-write of the count memory. An encode reads the code table entry,
// and a decode does one node memory read per path step. No new item is accepted
// until the block is back in idle.
// Build after tlast: a scan over the symbols with an ordered insertion of each
// leaf into the order list, then the merges, each placing its sum by a compare
// scan of the list, then the code pass over the internal nodes.
// Reset clears the counts, the code table presence bits and the tree (queries then
// report not found and decode to zero); no memory clearing pass is needed.
// When the receiver stalls, the result waits in the output register and the
// block holds its next result until that register is taken.
module prefix_code_tree_builder #(
    parameter int ALPHABET_SIZE = pctb_pkg::ALPHABET_SIZE_DEF,
    parameter int MAX_CODE_BITS = pctb_pkg::MAX_CODE_BITS_DEF,
    parameter int COUNT_BITS    = pctb_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // symbol [6:0], path_bits [38:7], path_length [44:39], zero pad [47:45]
    input  logic [pctb_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // mode [1:0]
    input  logic [pctb_pkg::MODE_W-1:0]     s_axis_tuser,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // code_bits [31:0], code_length [37:32], found [38], decoded_symbol [45:39],
    // distinct_symbols [52:46], overflow [53], zero pad [55:54]
    output logic [pctb_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import pctb_pkg::*;

    dp_cmd_t            cmd;
    dp_status_t         st;
    logic [PATH_W-1:0]  code_bits;
    logic [CLEN_W-1:0]  code_length;
    logic               found;
    logic [SYM_W-1:0]   decoded_symbol;
    logic [DIST_W-1:0]  distinct_symbols;
    logic               overflow;

    // Sequence the work
    pctb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_mode  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .st       (st)
    );

    // Hold counts, tree and codes
    pctb_datapath #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .COUNT_BITS    (COUNT_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .st               (st),
        .in_mode          (s_axis_tuser),
        .in_symbol        (s_axis_tdata[6:0]),
        .in_message_end   (s_axis_tlast),
        .in_path_bits     (s_axis_tdata[38:7]),
        .in_path_length   (s_axis_tdata[44:39]),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .code_bits        (code_bits),
        .code_length      (code_length),
        .found            (found),
        .decoded_symbol   (decoded_symbol),
        .distinct_symbols (distinct_symbols),
        .overflow         (overflow)
    );

    // Pack result transaction
    assign m_axis_tdata = {2'b00, overflow, distinct_symbols, decoded_symbol, found,
                           code_length, code_bits};

endmodule

[dv/prefix_code_tree_builder_tb.sv]
// Self-checking testbench of the prefix code tree builder: stream stimulus, tree predictor, scoreboard.
`timescale 1ns / 1ps

module prefix_code_tree_builder_tb;

    import pctb_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int ALPHA     = ALPHABET_SIZE_DEF;
    localparam int CODE_MAX  = MAX_CODE_BITS_DEF;
    localparam int NODES     = 2 * ALPHA - 1;
    localparam int COUNT_TOP = (1 << COUNT_BITS_DEF) - 1;

    typedef struct {
        logic [31:0] code_bits;
        logic [5:0]  code_length;
        logic        found;
        logic [6:0]  decoded_symbol;
        logic [6:0]  distinct_symbols;
        logic        overflow;
    } tree_result_t;

    // Tree predictor and the queue of results it still waits for
    class tree_scoreboard;
        int unsigned      counts [ALPHA];
        bit               started;
        bit               saturated;
        int               root;
        longint unsigned  weight [NODES];
        int               left_child [NODES];
        int               right_child [NODES];
        int               leaf_symbol [NODES];
        bit               is_leaf [NODES];
        bit [63:0]        node_code [NODES];
        int               node_depth [NODES];
        bit [63:0]        code_of [ALPHA];
        int               length_of [ALPHA];
        bit               present [ALPHA];
        tree_result_t     awaited [$];
        int               errors;

        function new();
            foreach (counts[i]) counts[i] = 0;
            foreach (present[i]) present[i] = 0;
            started = 0;
            saturated = 0;
            root = -1;
            errors = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Build the tree from the counts; return the leaf total
        function int build_tree(output bit too_long);
            int order [$];
            int n;
            int nxt;
            int pos;
            int a;
            int b;
            longint unsigned sum;
            n = 0;
            too_long = 0;
            foreach (present[i]) present[i] = 0;
            for (int s = 1; s < ALPHA; s++)
            begin
                if (counts[s] == 0)
                    continue;
                weight[n] = counts[s];
                leaf_symbol[n] = s;
                is_leaf[n] = 1;
                pos = order.size();
                while (pos > 0 && weight[order[pos - 1]] > weight[n])
                    pos--;
                order.insert(pos, n);
                n++;
            end
            if (n == 0)
            begin
                root = -1;
                return 0;
            end
            nxt = n;
            while (order.size() >= 2)
            begin
                a = order.pop_front();
                b = order.pop_front();
                sum = weight[a] + weight[b];
                weight[nxt] = sum;
                left_child[nxt] = a;
                right_child[nxt] = b;
                leaf_symbol[nxt] = 0;
                is_leaf[nxt] = 0;
                pos = 0;
                while (pos < order.size() && weight[order[pos]] < sum)
                    pos++;
                order.insert(pos, nxt);
                nxt++;
            end
            root = order[0];
            node_code[root] = 0;
            node_depth[root] = 0;
            // Push codes from the root down; children always have lower indexes
            for (int i = root; i >= 0; i--)
            begin
                if (is_leaf[i])
                    continue;
                node_depth[left_child[i]] = node_depth[i] + 1;
                node_depth[right_child[i]] = node_depth[i] + 1;
                node_code[left_child[i]] = node_code[i];
                node_code[right_child[i]] = node_code[i];
                if (node_depth[i] < CODE_MAX)
                    node_code[right_child[i]][node_depth[i]] = 1'b1;
            end
            for (int i = 0; i < n; i++)
            begin
                code_of[leaf_symbol[i]] = node_code[i];
                length_of[leaf_symbol[i]] = node_depth[i];
                present[leaf_symbol[i]] = 1;
                if (node_depth[i] > CODE_MAX)
                    too_long = 1;
            end
            return n;
        endfunction

        // Note an accepted transaction and queue the result it causes
        function void note_input(logic [1:0] mode, logic [6:0] sym, logic last,
                                 logic [31:0] path, logic [5:0] plen);
            tree_result_t r;
            bit too_long;
            int n;
            int node;
            int steps;
            bit ok;
            r = '{default: '0};
            if (mode == MODE_ADD)
            begin
                if (!started)
                begin
                    foreach (counts[i]) counts[i] = 0;
                    saturated = 0;
                    started = 1;
                end
                if (sym != 0)
                begin
                    if (counts[sym] >= COUNT_TOP)
                        saturated = 1;
                    else
                        counts[sym]++;
                end
                if (!last)
                    return;
                n = build_tree(too_long);
                started = 0;
                r.distinct_symbols = (n > 127) ? 7'd127 : n[6:0];
                r.overflow = saturated || too_long;
                awaited.push_back(r);
            end
            else if (mode == MODE_ENC)
            begin
                if (root >= 0 && sym != 0 && present[sym])
                begin
                    r.code_bits = code_of[sym][31:0];
                    r.code_length = 6'((length_of[sym] > CODE_MAX) ? CODE_MAX
                                                                   : length_of[sym]);
                    r.found = 1;
                    r.overflow = length_of[sym] > CODE_MAX;
                end
                awaited.push_back(r);
            end
            else if (mode == MODE_DEC)
            begin
                if (root >= 0)
                begin
                    node = root;
                    ok = 1;
                    steps = (plen > 32) ? 32 : plen;
                    for (int i = 0; i < steps; i++)
                    begin
                        if (is_leaf[node])
                        begin
                            ok = 0;
                            break;
                        end
                        node = path[i] ? right_child[node] : left_child[node];
                    end
                    if (ok && is_leaf[node])
                        r.decoded_symbol = 7'(leaf_symbol[node]);
                end
                awaited.push_back(r);
            end
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        // Compare one result transaction with the oldest expectation
        task check(logic [OUT_DATA_W-1:0] data);
            tree_result_t e;
            if (awaited.size() == 0)
            begin
                report($sformatf("unexpected result %h", data));
                return;
            end
            e = awaited.pop_front();
            if (data[31:0] !== e.code_bits)
                report($sformatf("code_bits %h, want %h", data[31:0], e.code_bits));
            if (data[37:32] !== e.code_length)
                report($sformatf("code_length %0d, want %0d", data[37:32], e.code_length));
            if (data[38] !== e.found)
                report($sformatf("found %b, want %b", data[38], e.found));
            if (data[45:39] !== e.decoded_symbol)
                report($sformatf("decoded_symbol %0d, want %0d", data[45:39],
                                 e.decoded_symbol));
            if (data[52:46] !== e.distinct_symbols)
                report($sformatf("distinct_symbols %0d, want %0d", data[52:46],
                                 e.distinct_symbols));
            if (data[53] !== e.overflow)
                report($sformatf("overflow %b, want %b", data[53], e.overflow));
            if (data[55:54] !== 2'b00)
                report("nonzero pad bits");
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [MODE_W-1:0]     s_axis_tuser;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    tree_scoreboard sb;
    bit             no_idle;
    bit             long_hold_req;
    int             sent;

    prefix_code_tree_builder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Offer one item, hold it until accepted, then idle a random stretch
    task automatic send_item(logic [1:0] mode, logic [6:0] sym, logic last,
                             logic [31:0] path, logic [5:0] plen);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tlast  <= last;
        s_axis_tdata  <= {3'b000, plen, path, sym};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_input(mode, sym, last, path, plen);
        sent++;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering until every expected result has come
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic send_message(int len, int k, int pool []);
        int idx;
        for (int i = 0; i < len; i++)
        begin
            idx = $urandom_range(0, $urandom_range(0, k - 1));
            send_item(MODE_ADD, 7'(pool[idx]), i == len - 1, $urandom, 6'($urandom));
        end
    endtask

    // Random query against the last built tree, mostly well formed
    task automatic send_query();
        int          kind;
        logic [6:0]  sym;
        logic [31:0] path;
        int          len;
        kind = $urandom_range(0, 9);
        sym = 7'($urandom_range(1, 127));
        if (sb.root >= 0)
            for (int t = 0; t < 200 && !sb.present[sym]; t++)
                sym = 7'($urandom_range(1, 127));
        path = $urandom;
        if (kind < 3)
            send_item(MODE_ENC, sym, 1'($urandom), path, 6'($urandom));
        else if (kind == 3)
            send_item(MODE_ENC, 7'($urandom), 1'($urandom), path, 6'($urandom));
        else if (kind < 7 && sb.present[sym])
        begin
            len = sb.length_of[sym] > 32 ? 32 : sb.length_of[sym];
            for (int i = 0; i < len; i++)
                path[i] = sb.code_of[sym][i];
            // Cut the path short now and then so it ends on a branch
            if (kind == 6 && len > 0)
                len = $urandom_range(0, len - 1);
            send_item(MODE_DEC, 7'($urandom), 1'($urandom), path, 6'(len));
        end
        else if (kind == 7)
            send_item(MODE_DEC, 7'($urandom), 1'($urandom), path,
                      6'($urandom_range(0, 63)));
        else if (kind == 8)
            send_item(MODE_UNUSED, 7'($urandom), 1'($urandom), path, 6'($urandom));
        else
            send_item(MODE_DEC, 7'($urandom), 1'($urandom), path,
                      6'($urandom_range(0, 8)));
    endtask

    // Receiver: check results and stall at random
    initial
    begin
        int hold;
        hold = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                sb.check(m_axis_tdata);
                hold = no_idle ? 0 : $urandom_range(0, 19);
            end
            if (long_hold_req)
            begin
                hold = 500;
                long_hold_req = 0;
            end
            if (hold > 0)
            begin
                m_axis_tready <= 1'b0;
                hold--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        #20ms;
        $display("FAIL prefix_code_tree_builder");
        $finish;
    end

    initial
    begin
        int pool [];
        int k;
        sb = new();
        no_idle = 0;
        long_hold_req = 0;
        sent = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = MODE_ADD;
        s_axis_tlast = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Queries on the empty tree, an ignored mode, an empty message
        send_item(MODE_ENC, 7'd127, 1'b0, 32'hFFFF_FFFF, 6'd63);
        send_item(MODE_DEC, 7'd0, 1'b1, 32'h0, 6'd0);
        send_item(MODE_UNUSED, 7'd5, 1'b1, 32'hFFFF_FFFF, 6'd63);
        send_item(MODE_ADD, 7'd0, 1'b1, 32'h0, 6'd0);
        // Single leaf tree: empty path hits it, any step goes past it
        send_item(MODE_ADD, 7'd127, 1'b0, 32'h0, 6'd0);
        send_item(MODE_ADD, 7'd127, 1'b1, 32'h0, 6'd0);
        send_item(MODE_ENC, 7'd127, 1'b0, 32'h0, 6'd0);
        send_item(MODE_ENC, 7'd0, 1'b0, 32'h0, 6'd0);
        send_item(MODE_DEC, 7'd0, 1'b0, 32'h0, 6'd0);
        send_item(MODE_DEC, 7'd0, 1'b0, 32'h1, 6'd1);
        // Small tree with ties; queries while the next message is open
        send_item(MODE_ADD, 7'd1, 1'b0, 32'h0, 6'd0);
        send_item(MODE_ADD, 7'd2, 1'b0, 32'h0, 6'd0);
        send_item(MODE_ADD, 7'd3, 1'b0, 32'h0, 6'd0);
        send_item(MODE_ADD, 7'd3, 1'b1, 32'h0, 6'd0);
        send_item(MODE_ADD, 7'd64, 1'b0, 32'h0, 6'd0);
        send_item(MODE_ENC, 7'd3, 1'b0, 32'h0, 6'd0);
        send_item(MODE_DEC, 7'd0, 1'b0, 32'hFFFF_FFFF, 6'd63);
        send_item(MODE_DEC, 7'd0, 1'b0, 32'h0, 6'd1);
        send_item(MODE_DEC, 7'd0, 1'b0, 32'h2, 6'd2);
        send_item(MODE_ADD, 7'd64, 1'b1, 32'h0, 6'd0);
        send_item(MODE_ENC, 7'd64, 1'b0, 32'h0, 6'd0);
        // Long receiver stall while queries keep coming
        long_hold_req = 1;
        repeat (20) send_query();
        drain();

        // Random messages, each followed by queries
        while (sent < 800)
        begin
            k = ($urandom_range(0, 7) == 0) ? 127 : $urandom_range(1, 12);
            pool = new[k];
            foreach (pool[i]) pool[i] = (k == 127) ? i + 1 : $urandom_range(0, 127);
            no_idle = ($urandom_range(0, 5) == 0);
            send_message((k == 127) ? $urandom_range(130, 300) : $urandom_range(1, 30),
                         k, pool);
            if ($urandom_range(0, 9) == 0)
            begin
                // Long receiver stall while queries keep coming
                long_hold_req = 1;
                repeat (40) send_query();
                drain();
            end
            else
                repeat ($urandom_range(1, 10)) send_query();
            if ($urandom_range(0, 7) == 0)
                drain();
        end

        drain();
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS prefix_code_tree_builder");
        else
            $display("FAIL prefix_code_tree_builder");
        $finish;
    end

endmodule
